### hdl/point_line_perpendicular_distance_assert.svh
// Assertion macros for the point-to-line distance block
`ifndef POINT_LINE_PERPENDICULAR_DISTANCE_ASSERT_SVH
`define POINT_LINE_PERPENDICULAR_DISTANCE_ASSERT_SVH

// consequent must hold in the same cycle
`define PLD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the following cycle
`define PLD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/pld_pkg.sv
// Shared constants and types of the point-to-line distance block
`timescale 1ns / 1ps

package pld_pkg;
	localparam int CoordBitsDef = 16;
	localparam int FracBitsDef  = 8;

	// per-item control that rides along the pipeline
	typedef struct packed {
		logic vld;
		logic zero;
		logic neg_x;
		logic neg_y;
	} pld_ctl_t;
endpackage

### hdl/pld_front.sv
// Front end: differences, products, sums, magnitudes and numerators
`timescale 1ns / 1ps

module pld_front #(
	parameter int COORD_BITS = pld_pkg::CoordBitsDef,
	parameter int FRAC_BITS  = pld_pkg::FracBitsDef,
	localparam int CW     = COORD_BITS,
	localparam int DW     = CW + 1,
	localparam int PW     = 2 * CW + 2,
	localparam int LEN_W  = 2 * CW + 2,
	localparam int DOT_W  = 2 * CW + 3,
	localparam int MAG_W  = 2 * CW + 2,
	localparam int FNUM_W = DW + MAG_W + FRAC_BITS,
	localparam int DNUM_W = 2 * MAG_W + 2 * FRAC_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_vld,
	input  logic signed [CW-1:0]   line_ax,
	input  logic signed [CW-1:0]   line_ay,
	input  logic signed [CW-1:0]   line_bx,
	input  logic signed [CW-1:0]   line_by,
	input  logic signed [CW-1:0]   query_x,
	input  logic signed [CW-1:0]   query_y,
	output pld_pkg::pld_ctl_t      ctl,
	output logic signed [CW-1:0]   o_ax,
	output logic signed [CW-1:0]   o_ay,
	output logic signed [CW-1:0]   o_px,
	output logic signed [CW-1:0]   o_py,
	output logic [FNUM_W-1:0]      fnum_x,
	output logic [FNUM_W-1:0]      fnum_y,
	output logic [DNUM_W-1:0]      dnum,
	output logic [LEN_W-1:0]       len2
);
	import pld_pkg::*;

	localparam int LO_W = MAG_W / 2;
	localparam int HI_W = MAG_W - LO_W;

	// valid bits, one per stage
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	// coordinates carried along
	logic signed [CW-1:0] ax_s1, ay_s1, bx_s1, by_s1, px_s1, py_s1;
	logic signed [CW-1:0] ax_s2, ay_s2, px_s2, py_s2;
	logic signed [CW-1:0] ax_s3, ay_s3, px_s3, py_s3;
	logic signed [CW-1:0] ax_s4, ay_s4, px_s4, py_s4;
	logic signed [CW-1:0] ax_s5, ay_s5, px_s5, py_s5;
	logic signed [CW-1:0] ax_s6, ay_s6, px_s6, py_s6;
	logic signed [CW-1:0] ax_s7, ay_s7, px_s7, py_s7;

	logic signed [DW-1:0]    dx_s2, dy_s2, ex_s2, ey_s2;
	logic signed [DW-1:0]    dx_s3, dy_s3, dx_s4, dy_s4;
	logic signed [PW-1:0]    pxx_s3, pyy_s3, pdx_s3, pdy_s3, pc1_s3, pc2_s3;
	logic [LEN_W-1:0]        len2_s4, len2_s5, len2_s6, len2_s7;
	logic signed [DOT_W-1:0] dot_s4, cr_s4;
	logic [DW-1:0]           dxm_s5, dym_s5;
	logic [MAG_W-1:0]        dotm_s5, crm_s5;
	logic                    zero_s5, negx_s5, negy_s5;
	logic                    zero_s6, negx_s6, negy_s6;
	logic                    zero_s7, negx_s7, negy_s7;
	logic [DW+MAG_W-1:0]     fx_s6, fy_s6;
	logic [2*HI_W-1:0]       hh_s6;
	logic [HI_W+LO_W-1:0]    hl_s6;
	logic [2*LO_W-1:0]       ll_s6;
	logic [FNUM_W-1:0]       fnx_s7, fny_s7;
	logic [DNUM_W-1:0]       dnum_s7;

	// sign extension of a coordinate to difference width
	function automatic logic signed [DW-1:0] line_bx_ext(input logic signed [CW-1:0] v);
		line_bx_ext = DW'(v);
	endfunction

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// coordinate carry
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= line_ax;
			ay_s1 <= line_ay;
			bx_s1 <= line_bx;
			by_s1 <= line_by;
			px_s1 <= query_x;
			py_s1 <= query_y;
			{ax_s2, ay_s2, px_s2, py_s2} <= {ax_s1, ay_s1, px_s1, py_s1};
			{ax_s3, ay_s3, px_s3, py_s3} <= {ax_s2, ay_s2, px_s2, py_s2};
			{ax_s4, ay_s4, px_s4, py_s4} <= {ax_s3, ay_s3, px_s3, py_s3};
			{ax_s5, ay_s5, px_s5, py_s5} <= {ax_s4, ay_s4, px_s4, py_s4};
			{ax_s6, ay_s6, px_s6, py_s6} <= {ax_s5, ay_s5, px_s5, py_s5};
			{ax_s7, ay_s7, px_s7, py_s7} <= {ax_s6, ay_s6, px_s6, py_s6};
		end
	end

	// s2 differences, s3 products, s4 sums
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s2  <= DW'(line_bx_ext(bx_s1)) - DW'(line_bx_ext(ax_s1));
			dy_s2  <= DW'(line_bx_ext(by_s1)) - DW'(line_bx_ext(ay_s1));
			ex_s2  <= DW'(line_bx_ext(px_s1)) - DW'(line_bx_ext(ax_s1));
			ey_s2  <= DW'(line_bx_ext(py_s1)) - DW'(line_bx_ext(ay_s1));
			dx_s3  <= dx_s2;
			dy_s3  <= dy_s2;
			pxx_s3 <= dx_s2 * dx_s2;
			pyy_s3 <= dy_s2 * dy_s2;
			pdx_s3 <= ex_s2 * dx_s2;
			pdy_s3 <= ey_s2 * dy_s2;
			pc1_s3 <= dx_s2 * ey_s2;
			pc2_s3 <= dy_s2 * ex_s2;
			dx_s4  <= dx_s3;
			dy_s4  <= dy_s3;
			len2_s4 <= LEN_W'($unsigned(pxx_s3)) + LEN_W'($unsigned(pyy_s3));
			dot_s4 <= DOT_W'(pdx_s3) + DOT_W'(pdy_s3);
			cr_s4  <= DOT_W'(pc1_s3) - DOT_W'(pc2_s3);
		end
	end

	// s5 magnitudes and signs, s6 multiplies, s7 numerators
	always_ff @(posedge clk) begin
		if (en) begin
			dxm_s5  <= dx_s4[DW-1] ? DW'(-dx_s4) : DW'(dx_s4);
			dym_s5  <= dy_s4[DW-1] ? DW'(-dy_s4) : DW'(dy_s4);
			dotm_s5 <= dot_s4[DOT_W-1] ? MAG_W'(-dot_s4) : MAG_W'(dot_s4);
			crm_s5  <= cr_s4[DOT_W-1] ? MAG_W'(-cr_s4) : MAG_W'(cr_s4);
			negx_s5 <= dx_s4[DW-1] ^ dot_s4[DOT_W-1];
			negy_s5 <= dy_s4[DW-1] ^ dot_s4[DOT_W-1];
			zero_s5 <= (len2_s4 == '0);
			len2_s5 <= len2_s4;

			fx_s6   <= dxm_s5 * dotm_s5;
			fy_s6   <= dym_s5 * dotm_s5;
			hh_s6   <= crm_s5[MAG_W-1:LO_W] * crm_s5[MAG_W-1:LO_W];
			hl_s6   <= crm_s5[MAG_W-1:LO_W] * crm_s5[LO_W-1:0];
			ll_s6   <= crm_s5[LO_W-1:0] * crm_s5[LO_W-1:0];
			{negx_s6, negy_s6, zero_s6} <= {negx_s5, negy_s5, zero_s5};
			len2_s6 <= len2_s5;

			fnx_s7  <= FNUM_W'(fx_s6) << FRAC_BITS;
			fny_s7  <= FNUM_W'(fy_s6) << FRAC_BITS;
			// cross product squared, scaled by 2^(2*FRAC_BITS)
			dnum_s7 <= (DNUM_W'(hh_s6) << (2 * LO_W + 2 * FRAC_BITS))
				+ (DNUM_W'(hl_s6) << (LO_W + 1 + 2 * FRAC_BITS))
				+ (DNUM_W'(ll_s6) << (2 * FRAC_BITS));
			{negx_s7, negy_s7, zero_s7} <= {negx_s6, negy_s6, zero_s6};
			len2_s7 <= len2_s6;
		end
	end

	assign ctl.vld   = vld_s7;
	assign ctl.zero  = zero_s7;
	assign ctl.neg_x = negx_s7;
	assign ctl.neg_y = negy_s7;
	assign o_ax   = ax_s7;
	assign o_ay   = ay_s7;
	assign o_px   = px_s7;
	assign o_py   = py_s7;
	assign fnum_x = fnx_s7;
	assign fnum_y = fny_s7;
	assign dnum   = dnum_s7;
	assign len2   = len2_s7;
endmodule

### hdl/pld_div.sv
// Pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module pld_div #(
	parameter int NUM_W = 59,
	parameter int DEN_W = 34,
	parameter int QUO_W = 26
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QUO_W-1:0] quo,
	output logic             rem_nz
);
	import pld_pkg::*;

	// numerator top bits are below den by range, so they seed the remainder
	logic [DEN_W-1:0] rem_s [1:QUO_W];
	logic [QUO_W-1:0] pq_s  [1:QUO_W];
	logic [DEN_W-1:0] den_s [1:QUO_W];

	for (genvar i = 0; i < QUO_W; i++) begin : g_stage
		logic [DEN_W-1:0] cur_rem;
		logic [QUO_W-1:0] cur_pq;
		logic [DEN_W-1:0] cur_den;
		logic [DEN_W:0]   shf;
		logic [DEN_W:0]   dif;

		if (i == 0) begin : g_first
			assign cur_rem = DEN_W'(num[NUM_W-1:QUO_W]);
			assign cur_pq  = num[QUO_W-1:0];
			assign cur_den = den;
		end else begin : g_next
			assign cur_rem = rem_s[i];
			assign cur_pq  = pq_s[i];
			assign cur_den = den_s[i];
		end

		// shift in next numerator bit, trial subtract
		assign shf = {cur_rem, cur_pq[QUO_W-1]};
		assign dif = shf - {1'b0, cur_den};

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[i+1] <= cur_den;
				if (!dif[DEN_W]) begin
					rem_s[i+1] <= dif[DEN_W-1:0];
					pq_s[i+1]  <= {cur_pq[QUO_W-2:0], 1'b1};
				end else begin
					rem_s[i+1] <= shf[DEN_W-1:0];
					pq_s[i+1]  <= {cur_pq[QUO_W-2:0], 1'b0};
				end
			end
		end
	end

	assign quo    = pq_s[QUO_W];
	assign rem_nz = (rem_s[QUO_W] != '0);
endmodule

### hdl/pld_sqrt.sv
// Pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps

module pld_sqrt #(
	parameter int RT_W = 25
) (
	input  logic              clk,
	input  logic              en,
	input  logic [2*RT_W-1:0] rad,
	output logic [RT_W-1:0]   root
);
	import pld_pkg::*;

	localparam int RW = RT_W + 2;

	logic [RW-1:0]     rem_s  [1:RT_W];
	logic [RT_W-1:0]   root_s [1:RT_W];
	logic [2*RT_W-1:0] xs_s   [1:RT_W];

	for (genvar i = 0; i < RT_W; i++) begin : g_stage
		logic [RW-1:0]     cur_rem;
		logic [RT_W-1:0]   cur_root;
		logic [2*RT_W-1:0] cur_xs;
		logic [RW+1:0]     remsh;
		logic [RW+2:0]     dif;

		if (i == 0) begin : g_first
			assign cur_rem  = '0;
			assign cur_root = '0;
			assign cur_xs   = rad;
		end else begin : g_next
			assign cur_rem  = rem_s[i];
			assign cur_root = root_s[i];
			assign cur_xs   = xs_s[i];
		end

		// bring down two radicand bits, try root*4+1
		assign remsh = {cur_rem, cur_xs[2*RT_W-1 -: 2]};
		assign dif   = (RW+3)'(remsh) - (RW+3)'({cur_root, 2'b01});

		always_ff @(posedge clk) begin
			if (en) begin
				xs_s[i+1] <= {cur_xs[2*RT_W-3:0], 2'b00};
				if (!dif[RW+2]) begin
					rem_s[i+1]  <= dif[RW-1:0];
					root_s[i+1] <= {cur_root[RT_W-2:0], 1'b1};
				end else begin
					rem_s[i+1]  <= remsh[RW-1:0];
					root_s[i+1] <= {cur_root[RT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign root = root_s[RT_W];
endmodule

### hdl/pld_dly.sv
// Enabled delay line for data that waits on the long arithmetic path
`timescale 1ns / 1ps

module pld_dly #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);
	import pld_pkg::*;

	logic [WIDTH-1:0] tap_q [DEPTH];

	// shift one place per enabled cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) tap_q[i] <= '0;
		end else if (en) begin
			tap_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) tap_q[i] <= tap_q[i-1];
		end
	end

	assign q = tap_q[DEPTH-1];
endmodule

### hdl/point_line_perpendicular_distance.sv
// Throughput: one item per cycle; the whole pipeline holds while the output waits.
// Depth is set by the distance path: a divider with one quotient bit per stage
// followed by a square root with one root bit per stage.
// Reset: arst_n clears all valid bits at once; no clearing pass.
`timescale 1ns / 1ps

module point_line_perpendicular_distance #(
	parameter int COORD_BITS = pld_pkg::CoordBitsDef,
	parameter int FRAC_BITS  = pld_pkg::FracBitsDef,
	localparam int IN_W  = ((6 * COORD_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((3 * (COORD_BITS + FRAC_BITS) + 5 + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// line_ax, line_ay, line_bx, line_by, query_x, query_y
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// foot_x, foot_y, perp_distance, zero pad
	output logic [OUT_W-1:0] m_tdata
);
	import pld_pkg::*;

	localparam int CW      = COORD_BITS;
	localparam int DW      = CW + 1;
	localparam int MAG_W   = 2 * CW + 2;
	localparam int LEN_W   = 2 * CW + 2;
	localparam int FOOT_W  = CW + FRAC_BITS + 2;
	localparam int DIST_W  = CW + FRAC_BITS + 1;
	localparam int FNUM_W  = DW + MAG_W + FRAC_BITS;
	localparam int DNUM_W  = 2 * MAG_W + 2 * FRAC_BITS;
	localparam int DQ_W    = 2 * DIST_W;
	localparam int LAT_D   = DQ_W + DIST_W;
	localparam int LAT_FD  = LAT_D - FOOT_W;
	localparam int CTL_W   = $bits(pld_ctl_t);
	localparam int SIDE_W  = CTL_W + 4 * CW;

	logic en;

	pld_ctl_t             ctl_f, ctl_d;
	logic signed [CW-1:0] ax_f, ay_f, px_f, py_f;
	logic signed [CW-1:0] ax_d, ay_d, px_d, py_d;
	logic [FNUM_W-1:0]    fnum_x, fnum_y;
	logic [DNUM_W-1:0]    dnum;
	logic [LEN_W-1:0]     len2;
	logic [FOOT_W-1:0]    qx, qy, qx_d, qy_d;
	logic                 rnzx, rnzy, rnzx_d, rnzy_d;
	logic [DQ_W-1:0]      dq;
	logic                 dq_nz;
	logic [DIST_W-1:0]    dist_root;
	logic [SIDE_W-1:0]    side_d;
	logic [FOOT_W-1:0]    off_x, off_y, foot_x, foot_y;
	logic [DIST_W-1:0]    dist_o;
	logic                 vld_q;
	logic [OUT_W-1:0]     data_q;

	// pipeline moves whenever the output register is free or being drained
	assign en       = !vld_q || m_tready;
	assign s_tready = en;

	pld_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (s_tvalid),
		.line_ax (s_tdata[0*CW +: CW]),
		.line_ay (s_tdata[1*CW +: CW]),
		.line_bx (s_tdata[2*CW +: CW]),
		.line_by (s_tdata[3*CW +: CW]),
		.query_x (s_tdata[4*CW +: CW]),
		.query_y (s_tdata[5*CW +: CW]),
		.ctl     (ctl_f),
		.o_ax    (ax_f),
		.o_ay    (ay_f),
		.o_px    (px_f),
		.o_py    (py_f),
		.fnum_x  (fnum_x),
		.fnum_y  (fnum_y),
		.dnum    (dnum),
		.len2    (len2)
	);

	// foot offsets along the line
	pld_div #(.NUM_W(FNUM_W), .DEN_W(LEN_W), .QUO_W(FOOT_W)) u_div_x (
		.clk (clk), .en (en), .num (fnum_x), .den (len2), .quo (qx), .rem_nz (rnzx)
	);
	pld_div #(.NUM_W(FNUM_W), .DEN_W(LEN_W), .QUO_W(FOOT_W)) u_div_y (
		.clk (clk), .en (en), .num (fnum_y), .den (len2), .quo (qy), .rem_nz (rnzy)
	);

	// squared distance, then its root
	pld_div #(.NUM_W(DNUM_W), .DEN_W(LEN_W), .QUO_W(DQ_W)) u_div_d (
		.clk (clk), .en (en), .num (dnum), .den (len2), .quo (dq), .rem_nz (dq_nz)
	);
	pld_sqrt #(.RT_W(DIST_W)) u_sqrt (
		.clk (clk), .en (en), .rad (dq), .root (dist_root)
	);

	// align foot quotients and sideband with the root
	pld_dly #(.WIDTH(2 * FOOT_W + 2), .DEPTH(LAT_FD)) u_dly_foot (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d      ({rnzy, qy, rnzx, qx}),
		.q      ({rnzy_d, qy_d, rnzx_d, qx_d})
	);
	pld_dly #(.WIDTH(SIDE_W), .DEPTH(LAT_D)) u_dly_side (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d      ({ctl_f, ax_f, ay_f, px_f, py_f}),
		.q      (side_d)
	);
	assign {ctl_d, ax_d, ay_d, px_d, py_d} = side_d;

	// floored signed offsets and final results
	always_comb begin
		off_x = ctl_d.neg_x ? FOOT_W'(-(qx_d + FOOT_W'(rnzx_d))) : qx_d;
		off_y = ctl_d.neg_y ? FOOT_W'(-(qy_d + FOOT_W'(rnzy_d))) : qy_d;
		if (ctl_d.zero) begin
			foot_x = FOOT_W'(px_d) << FRAC_BITS;
			foot_y = FOOT_W'(py_d) << FRAC_BITS;
			dist_o = '0;
		end else begin
			foot_x = (FOOT_W'(ax_d) << FRAC_BITS) + off_x;
			foot_y = (FOOT_W'(ay_d) << FRAC_BITS) + off_y;
			dist_o = dist_root;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= ctl_d.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= OUT_W'({dist_o, foot_y, foot_x});
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = data_q;

`include "point_line_perpendicular_distance_assert.svh"

	`PLD_ASSERT_NOW(a_stall_blocks_in, m_tvalid && !m_tready, !s_tready,
		"input taken while output stalled")
	`PLD_ASSERT_NEXT(a_zero_line_dist, en && ctl_d.vld && ctl_d.zero,
		m_tvalid && (m_tdata[2*FOOT_W +: DIST_W] == '0), "coincident points gave nonzero distance")
	`PLD_ASSERT_NEXT(a_pipe_holds, !en, $stable(side_d) && $stable(qx_d) && $stable(qy_d),
		"pipeline moved during stall")
endmodule

### tb/point_line_perpendicular_distance_tb.sv
// Self-checking testbench for the point-to-line perpendicular foot and distance block
`timescale 1ns / 1ps

module point_line_perpendicular_distance_tb;
	localparam int CB = pld_pkg::CoordBitsDef;
	localparam int FB = pld_pkg::FracBitsDef;
	localparam int FOOT_W = CB + FB + 2;
	localparam int DIST_W = CB + FB + 1;
	localparam int IN_W  = ((6 * CB + 7) / 8) * 8;
	localparam int OUT_W = ((3 * (CB + FB) + 5 + 7) / 8) * 8;
	localparam int LATENCY = 3 * (CB + FB + 1) + 7;
	localparam int N_RANDOM = 1100;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [DIST_W-1:0] pdist;
		logic [FOOT_W-1:0] fy;
		logic [FOOT_W-1:0] fx;
	} geo_result_t;

	// exact floor(num / den) for den > 0, num up to 128 bits signed
	function automatic logic signed [63:0] floor_div(logic signed [127:0] num,
			logic signed [127:0] den);
		logic signed [127:0] q;
		q = num / den;
		if ((num % den) != 0 && num < 0)
			q = q - 1;
		return q[63:0];
	endfunction

	// largest d with d*d*len2 <= cr^2 * 2^(2*FB)
	function automatic logic [63:0] scaled_root(logic [127:0] cr, logic [127:0] len2);
		logic [127:0] target;
		logic [127:0] cand;
		logic [63:0] d;
		target = (cr * cr) << (2 * FB);
		d = '0;
		for (int k = DIST_W - 1; k >= 0; k--) begin
			cand = 128'(d | (64'd1 << k));
			if (cand * cand * len2 <= target)
				d = cand[63:0];
		end
		return d;
	endfunction

	function automatic geo_result_t predict_foot(logic [IN_W-1:0] pkt);
		logic signed [127:0] ax, ay, bx, by, px, py, dx, dy, ex, ey, len2, dot, cr;
		logic signed [63:0] fx, fy;
		logic [63:0] root;
		geo_result_t r;
		ax = 128'($signed(pkt[0*CB +: CB]));
		ay = 128'($signed(pkt[1*CB +: CB]));
		bx = 128'($signed(pkt[2*CB +: CB]));
		by = 128'($signed(pkt[3*CB +: CB]));
		px = 128'($signed(pkt[4*CB +: CB]));
		py = 128'($signed(pkt[5*CB +: CB]));
		dx = bx - ax; dy = by - ay; ex = px - ax; ey = py - ay;
		len2 = dx * dx + dy * dy;
		if (len2 == 0) begin
			fx = 64'(px <<< FB);
			fy = 64'(py <<< FB);
			r.pdist = '0;
		end else begin
			dot = ex * dx + ey * dy;
			cr = dx * ey - dy * ex;
			if (cr < 0)
				cr = -cr;
			fx = 64'((ax <<< FB) + 128'(floor_div((dx * dot) <<< FB, len2)));
			fy = 64'((ay <<< FB) + 128'(floor_div((dy * dot) <<< FB, len2)));
			root = scaled_root(cr, len2);
			r.pdist = root[DIST_W-1:0];
		end
		r.fx = fx[FOOT_W-1:0];
		r.fy = fy[FOOT_W-1:0];
		return r;
	endfunction

	class foot_scoreboard;
		geo_result_t pending_feet[$];
		int errors;

		function void note_query(logic [IN_W-1:0] pkt);
			pending_feet.push_back(predict_foot(pkt));
		endfunction

		function void check_result(logic [OUT_W-1:0] data);
			geo_result_t got, want;
			got = data[FOOT_W*2+DIST_W-1:0];
			if (pending_feet.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %h", data);
				return;
			end
			want = pending_feet.pop_front();
			if (got.fx !== want.fx || got.fy !== want.fy || got.pdist !== want.pdist ||
					data[OUT_W-1:FOOT_W*2+DIST_W] !== '0) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp fx=%h fy=%h d=%h got fx=%h fy=%h d=%h pad=%h",
						want.fx, want.fy, want.pdist, got.fx, got.fy, got.pdist,
						data[OUT_W-1:FOOT_W*2+DIST_W]);
			end
		endfunction
	endclass

	logic clk, arst_n, s_tvalid, s_tready, m_tvalid, m_tready;
	logic [IN_W-1:0] s_tdata;
	logic [OUT_W-1:0] m_tdata;
	foot_scoreboard sb;
	longint cycles;
	bit sending_done;

	point_line_perpendicular_distance u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// record transfers on both sides
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_query(s_tdata);
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// receiver stall pattern: randomly chosen stretches of steady, random or periodic readiness
	initial begin
		int mode_left;
		int mode;
		m_tready = 0;
		mode_left = 0;
		mode = 0;
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(5, 120);
			end
			mode_left--;
			case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= (mode_left % 7 != 0);
			endcase
		end
	end

	// timeout watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	function automatic logic [CB-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
			1: return CB'($signed($urandom_range(0, 40)) - 20);
			default: return CB'($urandom);
		endcase
	endfunction

	task automatic send_query(logic [CB-1:0] ax, logic [CB-1:0] ay, logic [CB-1:0] bx,
			logic [CB-1:0] by, logic [CB-1:0] px, logic [CB-1:0] py);
		s_tdata <= {{(IN_W-6*CB){1'b0}}, py, px, by, bx, ay, ax};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic idle_cycles(int n);
		s_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_random();
		logic [CB-1:0] ax, ay, bx, by;
		ax = rand_coord(); ay = rand_coord();
		case ($urandom_range(0, 9))
			0: begin bx = ax; by = ay; end          // coincident points
			1: begin bx = ax; by = rand_coord(); end // vertical line
			2: begin bx = rand_coord(); by = ay; end // horizontal line
			default: begin bx = rand_coord(); by = rand_coord(); end
		endcase
		send_query(ax, ay, bx, by, rand_coord(), rand_coord());
	endtask

	localparam logic [CB-1:0] MAXC = {1'b0, {(CB-1){1'b1}}};
	localparam logic [CB-1:0] MINC = {1'b1, {(CB-1){1'b0}}};

	initial begin
		int sent;
		int burst;
		sb = new();
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		sending_done = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, axis-aligned lines, coincident points
		send_query(0, 0, 0, 0, 0, 0);
		send_query(5, 5, 5, 5, MAXC, MINC);
		send_query(MINC, MINC, MINC, MINC, MAXC, MAXC);
		send_query(3, MINC, 3, MAXC, MINC, 7);
		send_query(MINC, 0, MINC, 1, MAXC, MAXC);
		send_query(MINC, -CB'(2), MAXC, -CB'(2), 100, MINC);
		send_query(0, MAXC, 1, MAXC, MINC, MINC);
		send_query(MINC, MINC, MAXC, MAXC, MAXC, MINC);
		send_query(MINC, MAXC, MAXC, MINC, MINC, MINC);
		send_query(MAXC, MAXC, MINC, MINC, MINC, MAXC);
		send_query(0, 0, 1, 1, 1, 0);
		send_query(0, 0, 3, 1, -CB'(1), 2);
		send_query(0, 0, 1, 0, 2, -CB'(3));
		send_query(MINC, MINC, MINC + 1, MINC, MAXC, MAXC);
		send_query(MAXC, MINC, MINC, MAXC, MINC, MINC);
		send_query(-CB'(1), -CB'(1), 0, 0, -CB'(1), -CB'(1));
		send_query(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'hFFFF, 16'h0001);
		send_query(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h0001, 16'hFFFF);
		idle_cycles(1);

		// hold off until the pipeline has drained
		while (sb.pending_feet.size() != 0)
			@(posedge clk);

		// random part in bursts, most of them followed by a gap
		sent = 0;
		while (sent < N_RANDOM) begin
			burst = $urandom_range(1, 60);
			for (int i = 0; i < burst && sent < N_RANDOM; i++) begin
				send_random();
				sent++;
			end
			if ($urandom_range(0, 2) != 0)
				idle_cycles($urandom_range(1, 12));
			if (sent >= N_RANDOM / 2 && sent < N_RANDOM / 2 + 60)
				while (sb.pending_feet.size() != 0)
					idle_cycles(1);
		end
		s_tvalid <= 1'b0;

		while (sb.pending_feet.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
